/* src/rrst_pkg.sv */
// Shared constants, register codes and slice-unit types for the round-robin
// schedule timing block. Depends on nothing; every other file imports it.
package rrst_pkg;

	localparam int MAX_TASKS_DEF = 32;

	localparam int LABEL_W = 8;
	localparam int BURST_W = 8;
	localparam int TIME_W  = 14;
	localparam int SLICE_W = 8;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TIME_SLICE  = 1'b0,
		REG_POLICY_MODE = 1'b1
	} cfg_reg_t;

	localparam logic [SLICE_W-1:0] SLICE_RST  = 8'd2;
	localparam logic               POLICY_FCFS = 1'b0;
	localparam logic               POLICY_RR   = 1'b1;
	localparam logic               POLICY_RST  = POLICY_RR;

	typedef enum logic [1:0] {
		OP_SLICE = 2'b01,
		OP_WAIT  = 2'b10
	} alu_op_t;

	typedef struct packed {
		alu_op_t             op;
		logic                rr_mode;
		logic [SLICE_W-1:0]  quantum;
		logic [BURST_W-1:0]  rem;
		logic [TIME_W-1:0]   clk_now;
		logic [TIME_W-1:0]   fin;
		logic [BURST_W-1:0]  burst;
	} alu_req_t;

	typedef struct packed {
		logic                skip;
		logic                done;
		logic [BURST_W-1:0]  new_rem;
		logic [TIME_W-1:0]   new_clock;
		logic [TIME_W-1:0]   wait_val;
	} alu_rsp_t;

endpackage

/* src/rrst_if.sv */
// Handshake channel interfaces: task input, result output, register writes.
// Depends on rrst_pkg for field widths.
interface rrst_task_if import rrst_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LABEL_W-1:0] task_label;
	logic [BURST_W-1:0] burst_length;
	logic               final_task;

	modport source (output valid, output task_label, output burst_length,
		output final_task, input ready);
	modport sink (input valid, input task_label, input burst_length,
		input final_task, output ready);
endinterface

interface rrst_result_if import rrst_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LABEL_W-1:0] result_label;
	logic [TIME_W-1:0]  wait_time;
	logic [TIME_W-1:0]  finish_time;
	logic [TIME_W-1:0]  schedule_length;
	logic               last_result;

	modport source (output valid, output result_label, output wait_time,
		output finish_time, output schedule_length, output last_result, input ready);
	modport sink (input valid, input result_label, input wait_time,
		input finish_time, input schedule_length, input last_result, output ready);
endinterface

interface rrst_cfg_if import rrst_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* src/rrst_slice_alu.sv */
// Shared slice unit: one quantum clamp, one saturating time adder and one
// subtractor, reused for every slice and every waiting-time figure. Uses rrst_pkg.
module rrst_slice_alu import rrst_pkg::*; (
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [SLICE_W-1:0] q_eff;
	logic [BURST_W-1:0] run;
	logic [TIME_W:0]    sub_a;
	logic [TIME_W:0]    sub_b;
	logic [TIME_W:0]    diff;
	logic [TIME_W:0]    sum;

	always_comb begin
		// a zero quantum counts as one unit
		q_eff = (req.quantum == '0) ? SLICE_W'(1) : req.quantum;
		run   = (req.rr_mode && (req.rem > q_eff)) ? q_eff : req.rem;

		if (req.op == OP_WAIT) begin
			sub_a = {1'b0, req.fin};
			sub_b = (TIME_W+1)'(req.burst);
		end else begin
			sub_a = (TIME_W+1)'(req.rem);
			sub_b = (TIME_W+1)'(run);
		end
		diff = sub_a - sub_b;
		sum  = {1'b0, req.clk_now} + (TIME_W+1)'(run);

		rsp.skip      = req.rr_mode && (req.rem == '0);
		rsp.new_rem   = diff[BURST_W-1:0];
		rsp.done      = (diff[BURST_W-1:0] == '0);
		rsp.new_clock = (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[TIME_W-1:0];
		rsp.wait_val  = diff[TIME_W] ? '0 : diff[TIME_W-1:0];
	end

endmodule

/* src/rrst_ring.sv */
// Circular ready ring: a FIFO memory of task index and remaining burst,
// one push and one registered pop per cycle. Uses rrst_pkg.
module rrst_ring import rrst_pkg::*; #(
	parameter int DEPTH  = MAX_TASKS_DEF,
	parameter int DATA_W = 13
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic [DATA_W-1:0]           push_data,
	input  logic                        pop,
	output logic [DATA_W-1:0]           pop_data,
	output logic [$clog2(DEPTH+1)-1:0]  count
);

	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH+1);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] pop_data_q;
	logic [PW-1:0]     head_q;
	logic [PW-1:0]     tail_q;
	logic [CNT_W-1:0]  count_q;

	function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
		wrap_inc = (p == PW'(DEPTH-1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem[tail_q] <= push_data;
		end
		if (pop) begin
			pop_data_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= wrap_inc(tail_q);
			end
			if (pop) begin
				head_q <= wrap_inc(head_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign pop_data = pop_data_q;
	assign count    = count_q;

endmodule

/* src/rrst_task_store.sv */
// Per-task memories: label, burst and finish time, one write port and
// one registered read port each. Uses rrst_pkg.
module rrst_task_store import rrst_pkg::*; #(
	parameter int DEPTH = MAX_TASKS_DEF,
	parameter int IW    = 5
) (
	input  logic               clk,
	input  logic               ld_en,
	input  logic [IW-1:0]      ld_addr,
	input  logic [LABEL_W-1:0] ld_label,
	input  logic [BURST_W-1:0] ld_burst,
	input  logic               fin_wr_en,
	input  logic [IW-1:0]      fin_wr_addr,
	input  logic [TIME_W-1:0]  fin_wr_data,
	input  logic               rd_en,
	input  logic [IW-1:0]      rd_addr,
	output logic [LABEL_W-1:0] rd_label,
	output logic [BURST_W-1:0] rd_burst,
	output logic [TIME_W-1:0]  rd_fin
);

	logic [LABEL_W-1:0] label_mem  [DEPTH];
	logic [BURST_W-1:0] burst_mem  [DEPTH];
	logic [TIME_W-1:0]  finish_mem [DEPTH];

	logic [LABEL_W-1:0] rd_label_q;
	logic [BURST_W-1:0] rd_burst_q;
	logic [TIME_W-1:0]  rd_fin_q;

	always_ff @(posedge clk) begin
		if (ld_en) begin
			label_mem[ld_addr] <= ld_label;
			burst_mem[ld_addr] <= ld_burst;
		end
		// a freshly loaded task finishes at zero until the walk says otherwise
		if (ld_en) begin
			finish_mem[ld_addr] <= '0;
		end else if (fin_wr_en) begin
			finish_mem[fin_wr_addr] <= fin_wr_data;
		end
		if (rd_en) begin
			rd_label_q <= label_mem[rd_addr];
			rd_burst_q <= burst_mem[rd_addr];
			rd_fin_q   <= finish_mem[rd_addr];
		end
	end

	assign rd_label = rd_label_q;
	assign rd_burst = rd_burst_q;
	assign rd_fin   = rd_fin_q;

endmodule

/* src/round_robin_schedule_timing_unit.sv */
// Top level of the round-robin / FCFS schedule timing block: sequencer,
// registers and result register. Uses rrst_pkg, rrst_if, rrst_ring,
// rrst_task_store and rrst_slice_alu.
//
// Usage:
//   task_chan   - one transaction per task (label, burst, final flag). Tasks
//                 load at one per cycle; a task beyond MAX_TASKS is dropped.
//   cfg_chan    - register writes (index 0 time slice, 1 policy mode), always
//                 ready; write them only while no task set is in flight.
//   result_chan - one transaction per held task, in load order, after the
//                 transaction carrying final_task = 1.
// Timing: after the final task the block is not ready while it walks the
// schedule: each ring turn is a pop from the ring memory (S_POP) and then
// a pass through the slice unit (S_SLICE), per slice in round robin or per
// task in FCFS; each result is then a task memory read (S_EMIT_RD) and then
// a load of the result register (S_EMIT). A turn needs its own pop state
// because the ring memory's single read port is registered.
// Reset: clears the sequencer, task count, ring pointers and registers
// (time slice 2, round robin). Memories are not cleared.
// Stalls: the result register holds while result_chan.ready is low and the
// sequencer waits; a new set can load while the last result is still held.
module round_robin_schedule_timing_unit import rrst_pkg::*; #(
	parameter int MAX_TASKS = MAX_TASKS_DEF
) (
	input logic            clk,
	input logic            arst_n,
	rrst_task_if.sink      task_chan,
	rrst_result_if.source  result_chan,
	rrst_cfg_if.sink       cfg_chan
);

	localparam int IW      = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW      = $clog2(MAX_TASKS+1);
	localparam int ENTRY_W = IW + BURST_W;

	typedef enum logic [4:0] {
		S_LOAD    = 5'b00001,
		S_POP     = 5'b00010,
		S_SLICE   = 5'b00100,
		S_EMIT_RD = 5'b01000,
		S_EMIT    = 5'b10000
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      task_count_q;
	logic [TIME_W-1:0]  clock_q;
	logic [IW-1:0]      emit_idx_q;
	logic [SLICE_W-1:0] slice_q;
	logic               policy_q;

	logic               out_valid_q;
	logic [LABEL_W-1:0] out_label_q;
	logic [TIME_W-1:0]  out_wait_q;
	logic [TIME_W-1:0]  out_fin_q;
	logic [TIME_W-1:0]  out_len_q;
	logic               out_last_q;

	logic               task_acc;
	logic               store_ok;
	logic               ld_en;
	logic [IW-1:0]      ld_addr;

	logic               ring_push;
	logic [ENTRY_W-1:0] ring_push_data;
	logic               ring_pop;
	logic [ENTRY_W-1:0] ring_rd;
	logic [CW-1:0]      ring_count;
	logic [IW-1:0]      ring_idx;
	logic [BURST_W-1:0] ring_rem;

	logic               fin_wr_en;
	logic               st_rd_en;
	logic [LABEL_W-1:0] st_label;
	logic [BURST_W-1:0] st_burst;
	logic [TIME_W-1:0]  st_fin;

	alu_req_t           alu_req;
	alu_rsp_t           alu_rsp;

	logic               out_free;
	logic               emit_load;
	logic               emit_last;
	logic               slice_requeue;

	// task input: ready only while loading a set
	assign task_chan.ready = (state_q == S_LOAD);
	assign task_acc        = task_chan.valid & task_chan.ready;
	assign store_ok        = (task_count_q < CW'(MAX_TASKS));
	assign ld_en           = task_acc & store_ok;
	assign ld_addr         = task_count_q[IW-1:0];

	// ring entry: task index above, remaining burst below
	assign ring_idx = ring_rd[ENTRY_W-1:BURST_W];
	assign ring_rem = ring_rd[BURST_W-1:0];

	always_comb begin
		alu_req.op      = (state_q == S_EMIT) ? OP_WAIT : OP_SLICE;
		alu_req.rr_mode = (policy_q == POLICY_RR);
		alu_req.quantum = slice_q;
		alu_req.rem     = ring_rem;
		alu_req.clk_now = clock_q;
		alu_req.fin     = st_fin;
		alu_req.burst   = st_burst;
	end

	// requeue an unfinished task at the tail; drop zero-burst round-robin tasks
	assign slice_requeue = (state_q == S_SLICE) & ~alu_rsp.skip & ~alu_rsp.done;
	assign fin_wr_en     = (state_q == S_SLICE) & ~alu_rsp.skip & alu_rsp.done;

	always_comb begin
		if (state_q == S_LOAD) begin
			ring_push      = ld_en;
			ring_push_data = {ld_addr, task_chan.burst_length};
		end else begin
			ring_push      = slice_requeue;
			ring_push_data = {ring_idx, alu_rsp.new_rem};
		end
	end

	assign ring_pop  = (state_q == S_POP);
	assign st_rd_en  = (state_q == S_EMIT_RD);
	assign out_free  = ~out_valid_q | result_chan.ready;
	assign emit_load = (state_q == S_EMIT) & out_free;
	assign emit_last = ((CW'(emit_idx_q) + CW'(1)) == task_count_q);

	rrst_ring #(
		.DEPTH  (MAX_TASKS),
		.DATA_W (ENTRY_W)
	) u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (ring_push),
		.push_data (ring_push_data),
		.pop       (ring_pop),
		.pop_data  (ring_rd),
		.count     (ring_count)
	);

	rrst_task_store #(
		.DEPTH (MAX_TASKS),
		.IW    (IW)
	) u_store (
		.clk         (clk),
		.ld_en       (ld_en),
		.ld_addr     (ld_addr),
		.ld_label    (task_chan.task_label),
		.ld_burst    (task_chan.burst_length),
		.fin_wr_en   (fin_wr_en),
		.fin_wr_addr (ring_idx),
		.fin_wr_data (alu_rsp.new_clock),
		.rd_en       (st_rd_en),
		.rd_addr     (emit_idx_q),
		.rd_label    (st_label),
		.rd_burst    (st_burst),
		.rd_fin      (st_fin)
	);

	rrst_slice_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			task_count_q <= '0;
			clock_q      <= '0;
			emit_idx_q   <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (ld_en) begin
						task_count_q <= task_count_q + CW'(1);
					end
					if (task_acc && task_chan.final_task) begin
						clock_q <= '0;
						state_q <= S_POP;
					end
				end
				S_POP: begin
					state_q <= S_SLICE;
				end
				S_SLICE: begin
					if (!alu_rsp.skip) begin
						clock_q <= alu_rsp.new_clock;
					end
					// ring count already reflects this turn's pop
					if ((ring_count == '0) && !slice_requeue) begin
						emit_idx_q <= '0;
						state_q    <= S_EMIT_RD;
					end else begin
						state_q <= S_POP;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_load) begin
						if (emit_last) begin
							task_count_q <= '0;
							state_q      <= S_LOAD;
						end else begin
							emit_idx_q <= emit_idx_q + IW'(1);
							state_q    <= S_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// configuration registers
	assign cfg_chan.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_q  <= SLICE_RST;
			policy_q <= POLICY_RST;
		end else if (cfg_chan.valid) begin
			case (cfg_reg_t'(cfg_chan.index))
				REG_TIME_SLICE:  slice_q  <= cfg_chan.data[SLICE_W-1:0];
				REG_POLICY_MODE: policy_q <= cfg_chan.data[0];
				default:         slice_q  <= slice_q;
			endcase
		end
	end

	// result register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (result_chan.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_label_q <= st_label;
			out_wait_q  <= alu_rsp.wait_val;
			out_fin_q   <= st_fin;
			out_len_q   <= clock_q;
			out_last_q  <= emit_last;
		end
	end

	assign result_chan.valid           = out_valid_q;
	assign result_chan.result_label    = out_label_q;
	assign result_chan.wait_time       = out_wait_q;
	assign result_chan.finish_time     = out_fin_q;
	assign result_chan.schedule_length = out_len_q;
	assign result_chan.last_result     = out_last_q;

endmodule

/* src/rrst_checker.sv */
// Port-level checks for round_robin_schedule_timing_unit, attached by bind.
// Uses rrst_pkg for widths only.
module rrst_checker import rrst_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              in_final,
	input logic              out_valid,
	input logic              out_ready,
	input logic              out_last,
	input logic [TIME_W-1:0] out_wait,
	input logic [TIME_W-1:0] out_fin
);

	logic in_acc;
	logic out_acc;

	assign in_acc  = in_valid & in_ready;
	assign out_acc = out_valid & out_ready;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// the final task starts the walk, so no task is taken next cycle
	a_walk_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_final |=> !in_ready)
		else $error("task accepted straight after final task");

	// while a set is still being reported, no new task loads
	a_emit_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !out_last |-> !in_ready)
		else $error("task input open in the middle of a result set");

	// after the last result of a set, taken while task input is open, nothing follows at once
	a_set_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && out_last && in_ready |=> !out_valid)
		else $error("result offered straight after last result");

	// a task never waits longer than its turnaround
	a_wait_le_fin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_wait <= out_fin))
		else $error("waiting time exceeds finish time");

endmodule

bind round_robin_schedule_timing_unit rrst_checker u_rrst_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (task_chan.valid),
	.in_ready  (task_chan.ready),
	.in_final  (task_chan.final_task),
	.out_valid (result_chan.valid),
	.out_ready (result_chan.ready),
	.out_last  (result_chan.last_result),
	.out_wait  (result_chan.wait_time),
	.out_fin   (result_chan.finish_time)
);
